// ----- hw/rtl/llfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lattice Laplacian Fourier symbol package
// Shared widths, CORDIC constants, register indexes and pipeline depths.
// ----------------------------------------------------------------------------
package llfs_pkg;

  localparam int IDX_W        = 10;
  localparam int GRID_W       = 11;
  localparam int MODE_W       = 12;
  localparam int PH_W         = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CORDIC_STEPS = 24;
  localparam int SHIFT_W      = 5;
  localparam int XY_W         = 33;
  localparam int Z_W          = 34;
  localparam int GRAD_W       = 35;
  localparam int LAP_W        = 53;

  localparam logic [GRID_W-1:0] GRID_MAX = 11'd1024;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 33'sd652032874;

  localparam logic [PH_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 2'd2;

  localparam int AXIS_LAT   = 3 + CORDIC_STEPS + 3;
  localparam int LAP_LAT    = 4;
  localparam int PIPE_DEPTH = AXIS_LAT + LAP_LAT;

endpackage

`default_nettype wire

// ----- hw/rtl/lattice_laplacian_fourier_symbol_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lattice Laplacian Fourier symbol core
// Forward-difference gradient symbols and Laplacian symbol per grid point.
// ----------------------------------------------------------------------------
// The core accepts one (x, y, z) index beat per clock cycle unless stalled and
// returns one result beat per beat, in order. Each axis runs its own
// pipeline of 24 chained CORDIC cells, and the squared-gradient sum adds four
// stages, which together set the latency. A result that meets a stalled output
// moves into a one-beat holding register while the pipeline advances once more;
// the input stalls only while that register is full. Registers should be
// written only while the core is empty.
module lattice_laplacian_fourier_symbol_core
  import llfs_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [IDX_W-1:0]        x_index_i,
  input  wire logic [IDX_W-1:0]        y_index_i,
  input  wire logic [IDX_W-1:0]        z_index_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [GRAD_W-1:0]     grad_x_re_o,
  output logic signed [GRAD_W-1:0]     grad_x_im_o,
  output logic signed [GRAD_W-1:0]     grad_y_re_o,
  output logic signed [GRAD_W-1:0]     grad_y_im_o,
  output logic signed [GRAD_W-1:0]     grad_z_re_o,
  output logic signed [GRAD_W-1:0]     grad_z_im_o,
  output logic signed [LAP_W-1:0]      lap_re_o,
  output logic signed [LAP_W-1:0]      lap_im_o
);

  logic                    adv;
  logic [PIPE_DEPTH-1:0]   vld_q;
  logic                    skid_vld_q;
  logic [GRID_W-1:0]       grid_size_q;
  logic [PH_W-1:0]         phase_step_q;
  logic [CFG_W-1:0]        inv_spacing_q;
  logic [IDX_W-1:0]        idx [3];
  logic signed [GRAD_W-1:0] g_w  [6];
  logic signed [GRAD_W-1:0] g1_q [6];
  logic signed [GRAD_W-1:0] g2_q [6];
  logic signed [GRAD_W-1:0] g3_q [6];
  logic signed [GRAD_W-1:0] gout_q [6];
  logic signed [GRAD_W-1:0] gskid_q [6];
  logic signed [LAP_W-1:0] lap_re_q, lap_im_q;
  logic signed [LAP_W-1:0] lap_re_skid_q, lap_im_skid_q;
  logic [GRAD_W-1:0]       mag_q [6];
  logic                    neg_q [3];
  logic                    neg2_q [3];
  logic [69:0]             prr_q [3];
  logic [69:0]             pii_q [3];
  logic [69:0]             pri_q [3];
  logic [69:0]             rrr [3];
  logic [69:0]             rii [3];
  logic [69:0]             rri [3];
  logic signed [54:0]      mrr_q [3];
  logic signed [54:0]      mii_q [3];
  logic signed [54:0]      mri_q [3];
  logic signed [57:0]      lre, lim;

  function automatic logic signed [LAP_W-1:0] sat_lap(input logic signed [57:0] v);
    if (v > 58'sh0F_FFFF_FFFF_FFFF)       return {1'b0, {(LAP_W-1){1'b1}}};
    else if (v < -58'sh10_0000_0000_0000) return {1'b1, {(LAP_W-1){1'b0}}};
    else                                  return v[LAP_W-1:0];
  endfunction

  assign adv         = !skid_vld_q;
  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = skid_vld_q || vld_q[PIPE_DEPTH-1];

  assign grad_x_re_o = skid_vld_q ? gskid_q[0] : gout_q[0];
  assign grad_x_im_o = skid_vld_q ? gskid_q[1] : gout_q[1];
  assign grad_y_re_o = skid_vld_q ? gskid_q[2] : gout_q[2];
  assign grad_y_im_o = skid_vld_q ? gskid_q[3] : gout_q[3];
  assign grad_z_re_o = skid_vld_q ? gskid_q[4] : gout_q[4];
  assign grad_z_im_o = skid_vld_q ? gskid_q[5] : gout_q[5];
  assign lap_re_o    = skid_vld_q ? lap_re_skid_q : lap_re_q;
  assign lap_im_o    = skid_vld_q ? lap_im_skid_q : lap_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q   <= GRID_MAX;
      phase_step_q  <= 32'd4194304;
      inv_spacing_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_SIZE:   grid_size_q   <= cfg_data_i[GRID_W-1:0];
        REG_PHASE_STEP:  phase_step_q  <= cfg_data_i;
        REG_INV_SPACING: inv_spacing_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      skid_vld_q <= out_stall_i;
    end else begin
      skid_vld_q <= vld_q[PIPE_DEPTH-1] && out_stall_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      for (int k = 0; k < 6; k++) begin
        gskid_q[k] <= gout_q[k];
      end
      lap_re_skid_q <= lap_re_q;
      lap_im_skid_q <= lap_im_q;
    end
  end

  assign idx[0] = x_index_i;
  assign idx[1] = y_index_i;
  assign idx[2] = z_index_i;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    llfs_axis u_axis (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (adv),
      .idx_i         (idx[k]),
      .grid_size_i   (grid_size_q),
      .phase_step_i  (phase_step_q),
      .inv_spacing_i (inv_spacing_q),
      .grad_re_o     (g_w[2*k]),
      .grad_im_o     (g_w[2*k+1])
    );
  end

  always_comb begin
    lre = '0;
    lim = '0;
    for (int k = 0; k < 3; k++) begin
      rrr[k] = prr_q[k] + 70'h8000;
      rii[k] = pii_q[k] + 70'h8000;
      rri[k] = pri_q[k] + 70'h8000;
      lre    = lre + 58'(mrr_q[k]) - 58'(mii_q[k]);
      lim    = lim + (58'(mri_q[k]) <<< 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        g1_q[k]   <= g_w[k];
        mag_q[k]  <= g_w[k][GRAD_W-1] ? GRAD_W'(-g_w[k]) : GRAD_W'(g_w[k]);
        g2_q[k]   <= g1_q[k];
        g3_q[k]   <= g2_q[k];
        gout_q[k] <= g3_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        neg_q[k]  <= g_w[2*k][GRAD_W-1] ^ g_w[2*k+1][GRAD_W-1];
        neg2_q[k] <= neg_q[k];
        prr_q[k]  <= 70'(mag_q[2*k]) * 70'(mag_q[2*k]);
        pii_q[k]  <= 70'(mag_q[2*k+1]) * 70'(mag_q[2*k+1]);
        pri_q[k]  <= 70'(mag_q[2*k]) * 70'(mag_q[2*k+1]);
        mrr_q[k]  <= $signed({1'b0, rrr[k][69:16]});
        mii_q[k]  <= $signed({1'b0, rii[k][69:16]});
        mri_q[k]  <= neg2_q[k] ? -$signed({1'b0, rri[k][69:16]})
                               : $signed({1'b0, rri[k][69:16]});
      end
      lap_re_q <= sat_lap(lre);
      lap_im_q <= sat_lap(lim);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/llfs_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One registered micro-rotation; cells are chained to form the rotator.
// ----------------------------------------------------------------------------
module llfs_cordic_cell
  import llfs_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [SHIFT_W-1:0]      shift_i,
  input  wire logic [PH_W-1:0]         atan_i,
  input  wire logic signed [XY_W-1:0]  x_i,
  input  wire logic signed [XY_W-1:0]  y_i,
  input  wire logic signed [Z_W-1:0]   z_i,
  output logic signed [XY_W-1:0]       x_o,
  output logic signed [XY_W-1:0]       y_o,
  output logic signed [Z_W-1:0]        z_o
);

  logic signed [XY_W-1:0] dx, dy, x_d, y_d;
  logic signed [Z_W-1:0]  t, z_d;

  always_comb begin
    dx = y_i >>> shift_i;
    dy = x_i >>> shift_i;
    t  = $signed({{(Z_W-PH_W){1'b0}}, atan_i});
    if (!z_i[Z_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - t;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/llfs_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Axis gradient symbol pipeline
// Index to mode, phase, quadrant fold, CORDIC chain and scaled gradient.
// ----------------------------------------------------------------------------
module llfs_axis
  import llfs_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic [IDX_W-1:0]          idx_i,
  input  wire logic [GRID_W-1:0]         grid_size_i,
  input  wire logic [PH_W-1:0]           phase_step_i,
  input  wire logic [CFG_W-1:0]          inv_spacing_i,
  output logic signed [GRAD_W-1:0]       grad_re_o,
  output logic signed [GRAD_W-1:0]       grad_im_o
);

  logic [MODE_W-1:0]       mode_q, mode_d;
  logic [PH_W-1:0]         phase_q;
  logic signed [Z_W-1:0]   z0_q, z0_d;
  logic                    flip_d;
  logic [CORDIC_STEPS:0]   flip_q;
  logic signed [XY_W-1:0]  x_w [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  y_w [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]   z_w [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  xs, ys;
  logic signed [27:0]      c_q, s_q, c_d, s_d;
  logic signed [28:0]      cm;
  logic signed [32:0]      inv_s;
  logic signed [61:0]      pre_q, pim_q;
  logic signed [61:0]      tre, tim;

  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [37:0] v);
    if (v > 38'sh3_FFFF_FFFF)       return {1'b0, {(GRAD_W-1){1'b1}}};
    else if (v < -38'sh4_0000_0000) return {1'b1, {(GRAD_W-1){1'b0}}};
    else                            return v[GRAD_W-1:0];
  endfunction

  always_comb begin
    if ({1'b0, idx_i} > (grid_size_i >> 1)) begin
      mode_d = {2'b00, idx_i} - {1'b0, grid_size_i};
    end else begin
      mode_d = {2'b00, idx_i};
    end
  end

  always_comb begin
    flip_d = 1'b0;
    z0_d   = {{(Z_W-PH_W){phase_q[PH_W-1]}}, phase_q};
    if ($signed(phase_q) > 32'sh4000_0000) begin
      z0_d   = z0_d - 34'sh0_8000_0000;
      flip_d = 1'b1;
    end else if ($signed(phase_q) < -32'sh4000_0000) begin
      z0_d   = z0_d + 34'sh0_8000_0000;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q  <= mode_d;
      phase_q <= PH_W'({{(PH_W-MODE_W){mode_q[MODE_W-1]}}, mode_q} * phase_step_i);
      z0_q    <= z0_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= '0;
    end else if (en_i) begin
      flip_q <= {flip_q[CORDIC_STEPS-1:0], flip_d};
    end
  end

  assign x_w[0] = CORDIC_GAIN_INV;
  assign y_w[0] = '0;
  assign z_w[0] = z0_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    llfs_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .shift_i (SHIFT_W'(i)),
      .atan_i  (ATAN_TURNS[i]),
      .x_i     (x_w[i]),
      .y_i     (y_w[i]),
      .z_i     (z_w[i]),
      .x_o     (x_w[i+1]),
      .y_o     (y_w[i+1]),
      .z_o     (z_w[i+1])
    );
  end

  always_comb begin
    xs  = x_w[CORDIC_STEPS] + 33'sd32;
    ys  = y_w[CORDIC_STEPS] + 33'sd32;
    c_d = {xs[XY_W-1], xs[XY_W-1:6]};
    s_d = {ys[XY_W-1], ys[XY_W-1:6]};
    if (flip_q[CORDIC_STEPS]) begin
      c_d = -c_d;
      s_d = -s_d;
    end
    cm    = {c_q[27], c_q} - 29'sh100_0000;
    inv_s = $signed({1'b0, inv_spacing_i});
    tre   = pre_q + 62'sh80_0000;
    tim   = pim_q + 62'sh80_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q       <= c_d;
      s_q       <= s_d;
      pre_q     <= inv_s * cm;
      pim_q     <= inv_s * s_q;
      grad_re_o <= sat_grad(tre[61:24]);
      grad_im_o <= sat_grad(tim[61:24]);
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_lattice_laplacian_fourier_symbol_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice Laplacian Fourier symbol core testbench
// Drives index triples through the core under random idling on both sides,
// predicts each gradient and Laplacian symbol with a bit-exact CORDIC model,
// and checks every result beat in order across several register settings.
// ----------------------------------------------------------------------------
module tb_lattice_laplacian_fourier_symbol_core;
  import llfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int     LIMIT   = 300000;
  localparam longint QTR     = 64'sd1073741824;
  localparam longint HALF    = 64'sd2147483648;
  localparam longint GAIN    = 64'sd652032874;
  localparam longint ONE_Q24 = 64'sd16777216;
  localparam longint ANGLE [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    bit [IDX_W-1:0] x;
    bit [IDX_W-1:0] y;
    bit [IDX_W-1:0] z;
  } grid_point_t;

  typedef struct {
    longint v [8];
  } symbol_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [IDX_W-1:0] x_index_i = '0;
  logic [IDX_W-1:0] y_index_i = '0;
  logic [IDX_W-1:0] z_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [GRAD_W-1:0] grad_x_re_o, grad_x_im_o, grad_y_re_o, grad_y_im_o;
  logic signed [GRAD_W-1:0] grad_z_re_o, grad_z_im_o;
  logic signed [LAP_W-1:0] lap_re_o, lap_im_o;

  grid_point_t pending_points [$];
  symbol_t     expected_symbols [$];
  bit [10:0]   grid_size;
  bit [31:0]   phase_step;
  bit [31:0]   inv_spacing;
  bit          calm = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;

  lattice_laplacian_fourier_symbol_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sat_to(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    longint unsigned ua, ub, r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = (ua >> 16) * ub + (((ua & 64'hFFFF) * ub + 64'h8000) >> 16);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void cordic_sincos(bit [31:0] ph, output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = longint'($signed(ph));
    flip = 1'b0;
    if (a > QTR) begin
      a -= HALF;
      flip = 1'b1;
    end else if (a < -QTR) begin
      a += HALF;
      flip = 1'b1;
    end
    x = GAIN;
    y = 0;
    z = a;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ANGLE[i];
      end else begin
        x += dx;
        y -= dy;
        z += ANGLE[i];
      end
    end
    x = (x + 32) >>> 6;
    y = (y + 32) >>> 6;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic symbol_t laplacian_symbol(grid_point_t p);
    symbol_t r;
    longint idx, mode, c, s, re, im, lre, lim, inv;
    bit [31:0] m32, ph;
    lre = 0;
    lim = 0;
    inv = {32'b0, inv_spacing};
    for (int k = 0; k < 3; k++) begin
      idx = (k == 0) ? p.x : (k == 1) ? p.y : p.z;
      mode = idx;
      if (idx > longint'(grid_size >> 1)) mode = idx - longint'(grid_size);
      m32 = mode[31:0];
      ph = m32 * phase_step;
      cordic_sincos(ph, c, s);
      re = sat_to((inv * (c - ONE_Q24) + (ONE_Q24 >>> 1)) >>> 24, GRAD_W);
      im = sat_to((inv * s + (ONE_Q24 >>> 1)) >>> 24, GRAD_W);
      r.v[2 * k] = re;
      r.v[2 * k + 1] = im;
      lre += mul_q16(re, re) - mul_q16(im, im);
      lim += 2 * mul_q16(re, im);
    end
    r.v[6] = sat_to(lre, LAP_W);
    r.v[7] = sat_to(lim, LAP_W);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Driver: a beat is taken when valid is high and stall is low.
  always @(posedge clk_i) begin
    bit taken;
    grid_point_t p;
    taken = in_valid_i && !in_stall_o;
    if (taken) begin
      p.x = x_index_i;
      p.y = y_index_i;
      p.z = z_index_i;
      expected_symbols.push_back(laplacian_symbol(p));
    end
    if (!in_valid_i || taken) begin
      if (pending_points.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
        p = pending_points.pop_front();
        x_index_i <= p.x;
        y_index_i <= p.y;
        z_index_i <= p.z;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    symbol_t want;
    longint got [8];
    string names [8];
    names = '{"grad_x_re", "grad_x_im", "grad_y_re", "grad_y_im",
              "grad_z_re", "grad_z_im", "lap_re", "lap_im"};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{grad_x_re_o, grad_x_im_o, grad_y_re_o, grad_y_im_o,
              grad_z_re_o, grad_z_im_o, lap_re_o, lap_im_o};
      if (expected_symbols.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_symbols.pop_front();
        for (int k = 0; k < 8; k++)
          if (got[k] != want.v[k]) report_mismatch(names[k], got[k], want.v[k]);
      end
    end
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 13);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_points.size() > 0 || in_valid_i || expected_symbols.size() > 0)
      @(posedge clk_i);
    repeat (PIPE_DEPTH + 6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRID_SIZE:   grid_size = data[10:0];
      REG_PHASE_STEP:  phase_step = data;
      REG_INV_SPACING: inv_spacing = data;
      default: ;
    endcase
  endtask

  task automatic add_point(int x, int y, int z);
    grid_point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
  endtask

  task automatic run_random(int n);
    int lim;
    for (int i = 0; i < n; i++) begin
      if (grid_size >= 1 && grid_size <= 1024 && $urandom_range(99) < 85) begin
        lim = grid_size - 1;
        add_point($urandom_range(lim), $urandom_range(lim), $urandom_range(lim));
      end else begin
        add_point($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
      end
    end
    drain();
  endtask

  task automatic configure(logic [CFG_W-1:0] g, logic [CFG_W-1:0] ph, logic [CFG_W-1:0] inv);
    write_reg(REG_GRID_SIZE, g);
    write_reg(REG_PHASE_STEP, ph);
    write_reg(REG_INV_SPACING, inv);
  endtask

  initial begin
    grid_size = GRID_MAX;
    phase_step = 32'd4194304;
    inv_spacing = 32'd65536;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_point(0, 0, 0);
    add_point(1023, 1023, 1023);
    add_point(512, 512, 512);
    add_point(513, 513, 513);
    add_point(511, 1, 1022);
    add_point(256, 768, 0);
    add_point(1, 2, 3);
    add_point(341, 682, 1000);
    add_point(128, 896, 640);
    add_point(1022, 514, 2);
    add_point(682, 341, 85);
    drain();

    calm = 1'b1;
    run_random(100);
    calm = 1'b0;

    configure(32'd0, $urandom, $urandom);
    write_reg(REG_UNUSED, $urandom);
    add_point(0, 1023, 1);
    run_random(80);

    configure(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_point(0, 1023, 1);
    run_random(80);

    configure(32'hFFFF_FFFF, 32'd0, 32'd0);
    run_random(60);

    configure(32'd16, 32'h1000_0000, 32'd65536);
    run_random(100);

    for (int ph = 0; ph < 4; ph++) begin
      configure($urandom_range(1024, 2) | ($urandom & 32'hFFFF_F800), $urandom, $urandom);
      run_random(100);
    end

    configure(32'd1024, 32'h8000_0000, $urandom_range(32'h0010_0000));
    run_random(40);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
